// ===== design/tpa_pkg.sv =====
// Package with shared constants, codes and pipeline types for the permute address generator.
`default_nettype none
package tpa_pkg;

    localparam int MAX_RANK   = 6;
    localparam int INDEX_BITS = 32;
    localparam int SIZE_BITS  = 16;
    localparam int AXIS_BITS  = 3;
    localparam int ORDER_BITS = MAX_RANK * AXIS_BITS;
    localparam int RANK_BITS  = 3;
    localparam int CFG_BITS   = ORDER_BITS;
    localparam int DIV_STEP   = 4;
    localparam int DIV_STAGES = INDEX_BITS / DIV_STEP;
    localparam int WORK_BITS  = INDEX_BITS + SIZE_BITS;
    localparam int CNT_BITS   = INDEX_BITS + 1;
    localparam int STEP_BITS  = 3;

    typedef enum logic [2:0] {
        REG_RANK  = 3'd0,
        REG_ORDER = 3'd1,
        REG_SIZE0 = 3'd2,
        REG_SIZE1 = 3'd3,
        REG_SIZE2 = 3'd4,
        REG_SIZE3 = 3'd5,
        REG_SIZE4 = 3'd6,
        REG_SIZE5 = 3'd7
    } cfg_reg_t;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_RANGE     = 2'd1,
        ST_BAD_PERM  = 2'd2
    } status_t;

    typedef enum logic {
        SU_IDLE  = 1'b0,
        SU_SWEEP = 1'b1
    } setup_state_t;

    // Per-item pipeline record. work holds {remainder, dividend/quotient}.
    typedef struct packed {
        logic                    valid;
        status_t                 status;
        logic [WORK_BITS-1:0]    work;
        logic [INDEX_BITS-1:0]   prod;
        logic [INDEX_BITS-1:0]   acc;
    } tpa_pipe_t;

    // Derived setup handed from the setup unit to the datapath.
    typedef struct packed {
        logic                                   busy;
        logic                                   bad_perm;
        logic [CNT_BITS-1:0]                    count;
        logic [MAX_RANK-1:0][SIZE_BITS-1:0]     radix;
        logic [MAX_RANK-1:0][INDEX_BITS-1:0]    weight;
    } tpa_setup_t;

endpackage
`default_nettype wire

// ===== design/tpa_setup.sv =====
// Configuration registers and the sweep that derives strides, radices and element count.
`default_nettype none
module tpa_setup (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire logic                         cfg_valid,
    output logic                              cfg_ready,
    input  wire logic [2:0]                   cfg_index,
    input  wire logic [tpa_pkg::CFG_BITS-1:0] cfg_data,
    output tpa_pkg::tpa_setup_t               setup
);
    import tpa_pkg::*;

    logic [RANK_BITS-1:0]                 rank_reg;
    logic [ORDER_BITS-1:0]                order_reg;
    logic [MAX_RANK-1:0][SIZE_BITS-1:0]   size_reg;
    logic [MAX_RANK-1:0][INDEX_BITS-1:0]  stride_reg;
    logic [MAX_RANK-1:0][INDEX_BITS-1:0]  weight_reg;
    logic [MAX_RANK-1:0][SIZE_BITS-1:0]   radix_reg;
    logic [INDEX_BITS-1:0]                run_reg;
    logic [CNT_BITS-1:0]                  count_reg;
    logic                                 bad_reg;
    logic [STEP_BITS-1:0]                 step_reg;
    setup_state_t                         state_reg, state_next;
    logic                                 busy;
    logic                                 wr;
    logic                                 bad;
    logic [AXIS_BITS-1:0]                 axis_j;
    logic [SIZE_BITS-1:0]                 size_j;
    logic [INDEX_BITS+SIZE_BITS-1:0]      run_prod;
    logic [CNT_BITS+SIZE_BITS-1:0]        cnt_prod;

    assign cfg_ready = 1'b1;
    assign wr        = cfg_valid;

    // Permutation check over the fields below the rank; a rank of zero or above MAX_RANK is also bad.
    always_comb begin
        bad = (rank_reg == '0) || (rank_reg > RANK_BITS'(MAX_RANK));
        for (int j = 0; j < MAX_RANK; j++) begin
            if (RANK_BITS'(j) < rank_reg) begin
                if (order_reg[j*AXIS_BITS +: AXIS_BITS] >= rank_reg) bad = 1'b1;
                for (int k = 0; k < j; k++) begin
                    if (order_reg[j*AXIS_BITS +: AXIS_BITS] ==
                        order_reg[k*AXIS_BITS +: AXIS_BITS]) bad = 1'b1;
                end
            end
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            SU_IDLE:  if (wr) state_next = SU_SWEEP;
            SU_SWEEP: if (!wr && step_reg == STEP_BITS'(MAX_RANK)) state_next = SU_IDLE;
            default:  state_next = SU_SWEEP;
        endcase
    end

    always_comb begin
        case (state_reg)
            SU_IDLE: busy = 1'b0;
            default: busy = 1'b1;
        endcase
    end

    // The sweep walks source axes from innermost to outermost, one per cycle unless a configuration write restarts it.
    assign axis_j   = AXIS_BITS'(MAX_RANK - 1) - AXIS_BITS'(step_reg);
    assign size_j   = (step_reg < STEP_BITS'(MAX_RANK)) ? size_reg[axis_j] : SIZE_BITS'(1);
    assign run_prod = run_reg * size_j;
    assign cnt_prod = count_reg * size_j;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= SU_SWEEP;
            step_reg  <= '0;
            run_reg   <= INDEX_BITS'(1);
            count_reg <= CNT_BITS'(1);
            rank_reg  <= RANK_BITS'(1);
            order_reg <= ORDER_BITS'(181896);
            for (int k = 0; k < MAX_RANK; k++) size_reg[k] <= SIZE_BITS'(1);
        end else begin
            state_reg <= state_next;
            if (wr) begin
                step_reg  <= '0;
                run_reg   <= INDEX_BITS'(1);
                count_reg <= CNT_BITS'(1);
                case (cfg_index)
                    REG_RANK:  rank_reg  <= cfg_data[RANK_BITS-1:0];
                    REG_ORDER: order_reg <= cfg_data[ORDER_BITS-1:0];
                    default:   size_reg[AXIS_BITS'(cfg_index - REG_SIZE0)] <=
                                   cfg_data[SIZE_BITS-1:0];
                endcase
            end else if (busy) begin
                step_reg <= step_reg + STEP_BITS'(1);
                if (step_reg < STEP_BITS'(MAX_RANK) && RANK_BITS'(axis_j) < rank_reg) begin
                    run_reg <= run_prod[INDEX_BITS-1:0];
                    if (cnt_prod > (CNT_BITS+SIZE_BITS)'(1) << INDEX_BITS)
                        count_reg <= CNT_BITS'(1) << INDEX_BITS;
                    else
                        count_reg <= cnt_prod[CNT_BITS-1:0];
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!wr && busy) begin
            if (step_reg < STEP_BITS'(MAX_RANK)) begin
                stride_reg[axis_j] <= run_reg;
            end else begin
                bad_reg <= bad;
                for (int d = 0; d < MAX_RANK; d++) begin
                    if (RANK_BITS'(d) < rank_reg &&
                        order_reg[d*AXIS_BITS +: AXIS_BITS] < AXIS_BITS'(MAX_RANK)) begin
                        weight_reg[d] <= stride_reg[order_reg[d*AXIS_BITS +: AXIS_BITS]];
                        radix_reg[d]  <= (size_reg[order_reg[d*AXIS_BITS +: AXIS_BITS]] == '0) ?
                                         SIZE_BITS'(1) :
                                         size_reg[order_reg[d*AXIS_BITS +: AXIS_BITS]];
                    end else begin
                        weight_reg[d] <= '0;
                        radix_reg[d]  <= SIZE_BITS'(1);
                    end
                end
            end
        end
    end

    assign setup.busy     = busy;
    assign setup.bad_perm = bad_reg;
    assign setup.count    = count_reg;
    assign setup.radix    = radix_reg;
    assign setup.weight   = weight_reg;

endmodule
`default_nettype wire

// ===== design/tpa_div_stage.sv =====
// One pipeline stage of restoring division, four quotient bits per stage.
`default_nettype none
module tpa_div_stage (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          en,
    input  wire logic [tpa_pkg::SIZE_BITS-1:0] divisor,
    input  wire tpa_pkg::tpa_pipe_t            pipe_in,
    output tpa_pkg::tpa_pipe_t                 pipe_out
);
    import tpa_pkg::*;

    tpa_pipe_t             pipe_reg, pipe_next;
    logic [WORK_BITS-1:0]  w;
    logic [SIZE_BITS:0]    r;

    always_comb begin
        w = pipe_in.work;
        r = '0;
        for (int i = 0; i < DIV_STEP; i++) begin
            r = w[WORK_BITS-1:INDEX_BITS-1];
            w = {w[WORK_BITS-2:0], 1'b0};
            if (r >= {1'b0, divisor}) begin
                r    = r - {1'b0, divisor};
                w[0] = 1'b1;
            end
            w[WORK_BITS-1:INDEX_BITS] = r[SIZE_BITS-1:0];
        end
        pipe_next      = pipe_in;
        pipe_next.work = w;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pipe_reg.valid <= 1'b0;
        end else if (en) begin
            pipe_reg <= pipe_next;
        end
    end

    assign pipe_out = pipe_reg;

endmodule
`default_nettype wire

// ===== design/tpa_mac_stage.sv =====
// Two stages that weight one finished digit by its stride and add it to the sum.
`default_nettype none
module tpa_mac_stage (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           en,
    input  wire logic [tpa_pkg::INDEX_BITS-1:0] weight,
    input  wire tpa_pkg::tpa_pipe_t             pipe_in,
    output tpa_pkg::tpa_pipe_t                  pipe_out
);
    import tpa_pkg::*;

    tpa_pipe_t                         mul_reg, mul_next;
    tpa_pipe_t                         add_reg, add_next;
    logic [INDEX_BITS+SIZE_BITS-1:0]   prod;

    // The remainder is the digit; the quotient becomes the next dividend.
    assign prod = pipe_in.work[WORK_BITS-1:INDEX_BITS] * weight;

    always_comb begin
        mul_next      = pipe_in;
        mul_next.work = {{SIZE_BITS{1'b0}}, pipe_in.work[INDEX_BITS-1:0]};
        mul_next.prod = prod[INDEX_BITS-1:0];
        add_next      = mul_reg;
        add_next.acc  = mul_reg.acc + mul_reg.prod;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mul_reg.valid <= 1'b0;
            add_reg.valid <= 1'b0;
        end else if (en) begin
            mul_reg <= mul_next;
            add_reg <= add_next;
        end
    end

    assign pipe_out = add_reg;

endmodule
`default_nettype wire

// ===== design/tensor_permute_address_gen_core.sv =====
// Pipeline: 1 entry register, then 6 x (8 divide + 2 MAC) stages from input transaction to result.
// Throughput: one index per cycle while setup is idle; the whole pipeline advances when the output is free or taken.
// Each configuration write starts a setup sweep during which s_tready is low.
// Reset (aresetn, synchronous, active low) clears valid bits, loads reset register values
// and runs the same setup sweep before the first input transaction.
`default_nettype none
module tensor_permute_address_gen_core (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire logic                         s_tvalid,
    output logic                              s_tready,
    input  wire logic [31:0]                  s_tdata,   // [31:0] out_index
    output logic                              m_tvalid,
    input  wire logic                         m_tready,
    output logic [39:0]                       m_tdata,   // [31:0] src_index, [33:32] status
    input  wire logic                         cfg_valid,
    output logic                              cfg_ready,
    input  wire logic [2:0]                   cfg_index,
    input  wire logic [tpa_pkg::CFG_BITS-1:0] cfg_data
);
    import tpa_pkg::*;

    tpa_setup_t  setup;
    logic        en;
    tpa_pipe_t   entry_reg, entry_next;
    tpa_pipe_t   digit_pipe [MAX_RANK+1];
    tpa_pipe_t   chain [MAX_RANK][DIV_STAGES+1];
    tpa_pipe_t   last;

    tpa_setup u_setup (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .setup     (setup)
    );

    assign en       = !last.valid || m_tready;
    assign s_tready = en && !setup.busy;

    always_comb begin
        entry_next.valid = s_tvalid && s_tready;
        entry_next.work  = {{SIZE_BITS{1'b0}}, s_tdata};
        entry_next.prod  = '0;
        entry_next.acc   = '0;
        if (setup.bad_perm)
            entry_next.status = ST_BAD_PERM;
        else if ({1'b0, s_tdata} >= setup.count)
            entry_next.status = ST_RANGE;
        else
            entry_next.status = ST_OK;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            entry_reg.valid <= 1'b0;
        end else if (en) begin
            entry_reg <= entry_next;
        end
    end

    assign digit_pipe[0] = entry_reg;

    // Digits come off innermost output axis first.
    for (genvar g = 0; g < MAX_RANK; g++) begin : g_digit
        assign chain[g][0] = digit_pipe[g];
        for (genvar s = 0; s < DIV_STAGES; s++) begin : g_div
            tpa_div_stage u_div (
                .aclk     (aclk),
                .aresetn  (aresetn),
                .en       (en),
                .divisor  (setup.radix[MAX_RANK-1-g]),
                .pipe_in  (chain[g][s]),
                .pipe_out (chain[g][s+1])
            );
        end
        tpa_mac_stage u_mac (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .en       (en),
            .weight   (setup.weight[MAX_RANK-1-g]),
            .pipe_in  (chain[g][DIV_STAGES]),
            .pipe_out (digit_pipe[g+1])
        );
    end

    assign last     = digit_pipe[MAX_RANK];
    assign m_tvalid = last.valid;
    assign m_tdata  = {6'b0, last.status,
                       (last.status == ST_OK) ? last.acc : {INDEX_BITS{1'b0}}};

endmodule
`default_nettype wire
